[hw/rtl/pap_pkg.sv]
package pap_pkg;

  // Default sizes of the unit.
  localparam int unsigned MAX_VERTICES_DEF = 1024;
  localparam int unsigned COORD_BITS_DEF   = 16;
  localparam int unsigned FRAC_BITS_DEF    = 8;

  // Fixed widths of the result fields.
  localparam int unsigned AREA_W  = 41;
  localparam int unsigned PERIM_W = 35;
  localparam int unsigned TOTAL_W = 11;

  // Control of one bit-serial multiplier.
  typedef struct packed {
    logic load;       // take new operands and clear the accumulator
    logic step;       // consume one multiplier bit
    logic sign_step;  // the bit being consumed is the sign bit
  } mul_ctl_t;

endpackage

[hw/rtl/pap_if.sv]
interface pap_vertex_if #(
  parameter int unsigned COORD_BITS = pap_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic                         last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                  input ready);
  modport sink (input valid, input vertex_x, input vertex_y, input last_vertex,
                output ready);
endinterface

interface pap_result_if;
  import pap_pkg::*;

  logic               valid;
  logic               ready;
  logic [AREA_W-1:0]  area;
  logic               area_half;
  logic [PERIM_W-1:0] perimeter_q8;
  logic [TOTAL_W-1:0] vertex_total;
  logic               overflow;

  modport source (output valid, output area, output area_half, output perimeter_q8,
                  output vertex_total, output overflow, input ready);
  modport sink (input valid, input area, input area_half, input perimeter_q8,
                input vertex_total, input overflow, output ready);
endinterface

[hw/rtl/pap_smul.sv]
module pap_smul #(
  parameter int unsigned OP_W = pap_pkg::COORD_BITS_DEF + 1
) (
  input  logic               clk,
  input  pap_pkg::mul_ctl_t  ctl,
  input  logic [OP_W-1:0]    multiplicand,
  input  logic [OP_W-1:0]    multiplier,
  output logic [2*OP_W-1:0]  product
);
  localparam int unsigned PW = 2 * OP_W;

  // Shift-and-add over the multiplier bits, least significant first. Both
  // operands are two's complement, so the sign bit carries negative weight.
  logic [PW-1:0]   mcand;
  logic [PW-1:0]   acc;
  logic [OP_W-1:0] mplier;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mcand  <= {{OP_W{multiplicand[OP_W-1]}}, multiplicand};
      mplier <= multiplier;
      acc    <= '0;
    end else if (ctl.step) begin
      if (mplier[0]) begin
        if (ctl.sign_step) begin
          acc <= acc - mcand;
        end else begin
          acc <= acc + mcand;
        end
      end
      mcand  <= {mcand[PW-2:0], 1'b0};
      mplier <= {1'b0, mplier[OP_W-1:1]};
    end
  end

  assign product = acc;

endmodule

[hw/rtl/pap_root.sv]
module pap_root #(
  parameter int unsigned RAD_W     = 2 * (pap_pkg::COORD_BITS_DEF + 1),
  parameter int unsigned FRAC_BITS = pap_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [RAD_W-1:0]              radicand,
  output logic                          done,
  output logic [RAD_W/2+FRAC_BITS-1:0]  root
);
  localparam int unsigned STEPS  = RAD_W / 2 + FRAC_BITS;
  localparam int unsigned ROOT_W = STEPS;
  localparam int unsigned REM_W  = ROOT_W + 2;
  localparam int unsigned CNT_W  = (STEPS > 1) ? $clog2(STEPS) : 1;

  // Restoring square root, one result bit per cycle. The radicand is shifted
  // out two bits at a time; once it is empty, zero pairs follow and give the
  // fraction bits.
  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  always_comb begin
    rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
    trial  = {root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad <= {rad[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/polygon_area_perimeter.sv]
// Channel  Direction  Handshake      Payload
// -------  ---------  -------------  ------------------------------------------------
// vertex   in         valid / ready  vertex_x, vertex_y, last_vertex
// result   out        valid / ready  area, area_half, perimeter_q8, vertex_total, overflow
//
// An ordinary vertex runs its edge: the four bit-serial multipliers step through their
// multiplier bits, then the square-root unit works out the edge length. The last vertex
// of a polygon with an open edge runs its own edge and then the closing edge.
// Reset is synchronous and clears the sums, the vertex count and the result valid.
// A result waits in the output register; the next vertex is taken meanwhile, and only
// the close of a further polygon waits for that register to be emptied.
module polygon_area_perimeter #(
  parameter int unsigned MAX_VERTICES = pap_pkg::MAX_VERTICES_DEF,
  parameter int unsigned COORD_BITS   = pap_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS    = pap_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  pap_vertex_if.sink   vertex,
  pap_result_if.source result
);
  import pap_pkg::*;

  // Operand width: a coordinate difference needs one bit more than a coordinate.
  localparam int unsigned OP_W      = COORD_BITS + 1;
  localparam int unsigned PW        = 2 * OP_W;
  localparam int unsigned ROOT_W    = OP_W + FRAC_BITS;
  localparam int unsigned CNT_W     = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CROSS_W   = 2 * COORD_BITS + CNT_W;
  localparam int unsigned MUL_CNT_W = $clog2(OP_W);

  // IDLE takes a vertex. LOAD hands the edge to the multipliers, MUL steps them,
  // SUM folds the cross term into the area sum and starts the square root, ROOT
  // waits for the edge length, EMIT places the result in the output register.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_MUL  = 6'b000100,
    S_SUM  = 6'b001000,
    S_ROOT = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // Polygon state.
  logic [COORD_BITS-1:0] first_x;
  logic [COORD_BITS-1:0] first_y;
  logic [COORD_BITS-1:0] prev_x;
  logic [COORD_BITS-1:0] prev_y;
  logic [CROSS_W-1:0]    cross_sum;
  logic [PERIM_W-1:0]    length_sum;
  logic [CNT_W-1:0]      vertex_count;
  logic                  overflow_flag;

  // The edge being worked on runs from (ax, ay) to (bx, by).
  logic [COORD_BITS-1:0] ax;
  logic [COORD_BITS-1:0] ay;
  logic [COORD_BITS-1:0] bx;
  logic [COORD_BITS-1:0] by;
  logic                  closing_pending;
  logic                  is_closing;
  logic [MUL_CNT_W-1:0]  mul_cnt;

  logic                  accept;
  logic [COORD_BITS-1:0] in_x;
  logic [COORD_BITS-1:0] in_y;

  // Multiplier operands, all widened to OP_W bits.
  logic [OP_W-1:0] ax_w;
  logic [OP_W-1:0] ay_w;
  logic [OP_W-1:0] bx_w;
  logic [OP_W-1:0] by_w;
  logic [OP_W-1:0] dx;
  logic [OP_W-1:0] dy;
  mul_ctl_t        mul_ctl;

  logic [PW-1:0]        dx_sq;
  logic [PW-1:0]        dy_sq;
  logic [PW-1:0]        prod_ab;
  logic [PW-1:0]        prod_ba;
  logic signed [PW-1:0] cross_term;
  logic [PW-1:0]        dist_sq;

  logic              root_start;
  logic              root_done;
  logic [ROOT_W-1:0] root;

  logic [CROSS_W-1:0] cross_mag;

  assign vertex.ready = (state == S_IDLE);
  assign accept       = vertex.valid && vertex.ready;
  assign in_x         = vertex.vertex_x[COORD_BITS-1:0];
  assign in_y         = vertex.vertex_y[COORD_BITS-1:0];

  always_comb begin
    ax_w       = {ax[COORD_BITS-1], ax};
    ay_w       = {ay[COORD_BITS-1], ay};
    bx_w       = {bx[COORD_BITS-1], bx};
    by_w       = {by[COORD_BITS-1], by};
    dx         = bx_w - ax_w;
    dy         = by_w - ay_w;
    cross_term = prod_ab - prod_ba;
    dist_sq    = dx_sq + dy_sq;

    mul_ctl.load      = (state == S_LOAD);
    mul_ctl.step      = (state == S_MUL);
    mul_ctl.sign_step = (mul_cnt == MUL_CNT_W'(OP_W - 1));
    root_start        = (state == S_SUM);

    cross_mag = cross_sum[CROSS_W-1] ? (~cross_sum + CROSS_W'(1)) : cross_sum;
  end

  // Squares of the edge deltas feed the length; the two cross products give the
  // shoelace term for the edge.
  pap_smul #(.OP_W(OP_W)) u_mul_dx (
    .clk(clk), .ctl(mul_ctl), .multiplicand(dx), .multiplier(dx), .product(dx_sq)
  );
  pap_smul #(.OP_W(OP_W)) u_mul_dy (
    .clk(clk), .ctl(mul_ctl), .multiplicand(dy), .multiplier(dy), .product(dy_sq)
  );
  pap_smul #(.OP_W(OP_W)) u_mul_ab (
    .clk(clk), .ctl(mul_ctl), .multiplicand(ax_w), .multiplier(by_w), .product(prod_ab)
  );
  pap_smul #(.OP_W(OP_W)) u_mul_ba (
    .clk(clk), .ctl(mul_ctl), .multiplicand(bx_w), .multiplier(ay_w), .product(prod_ba)
  );

  pap_root #(.RAD_W(PW), .FRAC_BITS(FRAC_BITS)) u_root (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (dist_sq),
    .done     (root_done),
    .root     (root)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (vertex_count == '0) begin
            // A lone first vertex closing on itself still runs its empty edge.
            if (vertex.last_vertex) begin
              state_next = S_LOAD;
            end
          end else if (vertex_count < CNT_W'(MAX_VERTICES)) begin
            state_next = S_LOAD;
          end else if (vertex.last_vertex) begin
            state_next = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        state_next = S_MUL;
      end
      S_MUL: begin
        if (mul_ctl.sign_step) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        state_next = S_ROOT;
      end
      S_ROOT: begin
        if (root_done) begin
          if (closing_pending) begin
            state_next = S_LOAD;
          end else if (is_closing) begin
            state_next = S_EMIT;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (!result.valid || result.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      cross_sum       <= '0;
      length_sum      <= '0;
      vertex_count    <= '0;
      overflow_flag   <= 1'b0;
      closing_pending <= 1'b0;
      is_closing      <= 1'b0;
      result.valid    <= 1'b0;
    end else begin
      state <= state_next;

      // In EMIT the output register is refilled below, which also covers an item
      // leaving in the same cycle.
      if (result.valid && result.ready && state != S_EMIT) begin
        result.valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (vertex_count == '0) begin
              // The first vertex opens the polygon and adds no edge.
              first_x         <= in_x;
              first_y         <= in_y;
              prev_x          <= in_x;
              prev_y          <= in_y;
              vertex_count    <= CNT_W'(1);
              ax              <= in_x;
              ay              <= in_y;
              bx              <= in_x;
              by              <= in_y;
              is_closing      <= 1'b1;
              closing_pending <= 1'b0;
            end else if (vertex_count < CNT_W'(MAX_VERTICES)) begin
              ax              <= prev_x;
              ay              <= prev_y;
              bx              <= in_x;
              by              <= in_y;
              prev_x          <= in_x;
              prev_y          <= in_y;
              vertex_count    <= vertex_count + CNT_W'(1);
              is_closing      <= 1'b0;
              closing_pending <= vertex.last_vertex;
            end else begin
              // Too many vertices: this one is dropped, the polygon closes from
              // the last vertex that was taken.
              overflow_flag   <= 1'b1;
              ax              <= prev_x;
              ay              <= prev_y;
              bx              <= first_x;
              by              <= first_y;
              is_closing      <= 1'b1;
              closing_pending <= 1'b0;
            end
          end
        end
        S_LOAD: begin
          mul_cnt <= '0;
        end
        S_MUL: begin
          mul_cnt <= mul_cnt + MUL_CNT_W'(1);
        end
        S_SUM: begin
          cross_sum <= cross_sum + CROSS_W'(cross_term);
        end
        S_ROOT: begin
          if (root_done) begin
            length_sum <= length_sum + PERIM_W'(root);
            if (closing_pending) begin
              ax              <= prev_x;
              ay              <= prev_y;
              bx              <= first_x;
              by              <= first_y;
              is_closing      <= 1'b1;
              closing_pending <= 1'b0;
            end
          end
        end
        S_EMIT: begin
          if (!result.valid || result.ready) begin
            result.valid        <= 1'b1;
            result.area         <= AREA_W'(cross_mag[CROSS_W-1:1]);
            result.area_half    <= cross_mag[0];
            result.perimeter_q8 <= length_sum;
            result.vertex_total <= TOTAL_W'(vertex_count);
            result.overflow     <= overflow_flag;
            cross_sum           <= '0;
            length_sum          <= '0;
            vertex_count        <= '0;
            overflow_flag       <= 1'b0;
            is_closing          <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
